### sv/gpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_pkg
// shared types, request and register codes, and a mask helper for the gpio
// bank with pin interrupts
// ----------------------------------------------------------------------------
package gpb_pkg;

  localparam int unsigned GPB_WORD_W    = 32;
  localparam int unsigned GPB_PIN_COUNT = 32;
  localparam int unsigned GPB_HALF_PINS = 16;

  // request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register map
  localparam logic [2:0] REG_DATA      = 3'd0;
  localparam logic [2:0] REG_DIRECTION = 3'd1;
  localparam logic [2:0] REG_COND_LOW  = 3'd2;
  localparam logic [2:0] REG_COND_HIGH = 3'd3;
  localparam logic [2:0] REG_MASK      = 3'd4;
  localparam logic [2:0] REG_STATUS    = 3'd5;
  localparam logic [2:0] REG_BOTH_EDGE = 3'd6;

  // per-pin interrupt conditions
  localparam logic [1:0] COND_LOW_LEVEL  = 2'd0;
  localparam logic [1:0] COND_HIGH_LEVEL = 2'd1;
  localparam logic [1:0] COND_RISE       = 2'd2;
  localparam logic [1:0] COND_FALL       = 2'd3;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [2:0]            reg_index;
    logic [GPB_WORD_W-1:0] write_data;
    logic [GPB_WORD_W-1:0] pin_levels;
  } gpb_in_t;

  typedef struct packed {
    logic [GPB_WORD_W-1:0] read_data;
    logic                  irq_low_half;
    logic                  irq_high_half;
    logic [GPB_WORD_W-1:0] pin_drive;
    logic [GPB_WORD_W-1:0] pin_out_enable;
  } gpb_out_t;

  // word with the low n bits set
  function automatic logic [GPB_WORD_W-1:0] ones_mask(int unsigned n);
    logic [GPB_WORD_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < GPB_WORD_W; i++) begin
      m[i] = (i < n);
    end
    return m;
  endfunction

endpackage

### sv/gpb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_regs
// bus-mapped register file, pin edge/level detection and result formation
// ----------------------------------------------------------------------------
module gpb_regs
  import gpb_pkg::*;
#(
  parameter int unsigned PIN_COUNT = GPB_PIN_COUNT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  gpb_in_t  item,
  output gpb_out_t result
);

  localparam int unsigned LoPins = (PIN_COUNT < GPB_HALF_PINS) ? PIN_COUNT : GPB_HALF_PINS;
  localparam int unsigned HiPins = (PIN_COUNT > GPB_HALF_PINS) ? PIN_COUNT - GPB_HALF_PINS : 0;
  localparam logic [GPB_WORD_W-1:0] PinMask    = ones_mask(PIN_COUNT);
  localparam logic [GPB_WORD_W-1:0] CondLoMask = ones_mask(2 * LoPins);
  localparam logic [GPB_WORD_W-1:0] CondHiMask = ones_mask(2 * HiPins);

  logic [GPB_WORD_W-1:0] data_r,      data_nxt;
  logic [GPB_WORD_W-1:0] dir_r,       dir_nxt;
  logic [GPB_WORD_W-1:0] cond_lo_r,   cond_lo_nxt;
  logic [GPB_WORD_W-1:0] cond_hi_r,   cond_hi_nxt;
  logic [GPB_WORD_W-1:0] mask_r,      mask_nxt;
  logic [GPB_WORD_W-1:0] status_r,    status_nxt;
  logic [GPB_WORD_W-1:0] both_r,      both_nxt;
  logic [GPB_WORD_W-1:0] prev_pins_r, prev_pins_nxt;

  logic [GPB_WORD_W-1:0] cur_pins;
  logic [GPB_WORD_W-1:0] match;
  logic [GPB_WORD_W-1:0] read_word;
  logic [GPB_WORD_W-1:0] active;

  assign cur_pins = item.pin_levels & PinMask;

  // per-pin condition match against the last sampled levels
  always_comb begin
    logic [GPB_WORD_W-1:0] word;
    logic [1:0]            cond;
    word  = '0;
    cond  = COND_LOW_LEVEL;
    match = '0;
    for (int unsigned i = 0; i < GPB_WORD_W; i++) begin
      word = (i < GPB_HALF_PINS) ? cond_lo_r : cond_hi_r;
      cond = word[2 * (i % GPB_HALF_PINS) +: 2];
      if (both_r[i]) begin
        match[i] = cur_pins[i] ^ prev_pins_r[i];
      end else begin
        unique case (cond)
          COND_LOW_LEVEL:  match[i] = !cur_pins[i];
          COND_HIGH_LEVEL: match[i] = cur_pins[i];
          COND_RISE:       match[i] = !prev_pins_r[i] && cur_pins[i];
          COND_FALL:       match[i] = prev_pins_r[i] && !cur_pins[i];
          default:         match[i] = 1'b0;
        endcase
      end
    end
    match = match & PinMask;
  end

  // register read mux
  always_comb begin
    unique case (item.reg_index)
      REG_DATA:      read_word = data_r;
      REG_DIRECTION: read_word = dir_r;
      REG_COND_LOW:  read_word = cond_lo_r;
      REG_COND_HIGH: read_word = cond_hi_r;
      REG_MASK:      read_word = mask_r;
      REG_STATUS:    read_word = status_r;
      REG_BOTH_EDGE: read_word = both_r;
      default:       read_word = '0;
    endcase
  end

  // next state for the accepted transaction
  always_comb begin
    data_nxt      = data_r;
    dir_nxt       = dir_r;
    cond_lo_nxt   = cond_lo_r;
    cond_hi_nxt   = cond_hi_r;
    mask_nxt      = mask_r;
    status_nxt    = status_r;
    both_nxt      = both_r;
    prev_pins_nxt = prev_pins_r;
    unique case (item.req_type)
      REQ_WRITE: begin
        unique case (item.reg_index)
          REG_DATA:      data_nxt    = item.write_data & PinMask;
          REG_DIRECTION: dir_nxt     = item.write_data & PinMask;
          REG_COND_LOW:  cond_lo_nxt = item.write_data & CondLoMask;
          REG_COND_HIGH: cond_hi_nxt = item.write_data & CondHiMask;
          REG_MASK:      mask_nxt    = item.write_data & PinMask;
          REG_STATUS:    status_nxt  = status_r & ~item.write_data;
          REG_BOTH_EDGE: both_nxt    = item.write_data & PinMask;
          default:       ;
        endcase
      end
      REQ_TICK: begin
        status_nxt    = status_r | match;
        prev_pins_nxt = cur_pins;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r      <= '0;
      dir_r       <= '0;
      cond_lo_r   <= '0;
      cond_hi_r   <= '0;
      mask_r      <= '0;
      status_r    <= '0;
      both_r      <= '0;
      prev_pins_r <= '0;
    end else if (accept) begin
      data_r      <= data_nxt;
      dir_r       <= dir_nxt;
      cond_lo_r   <= cond_lo_nxt;
      cond_hi_r   <= cond_hi_nxt;
      mask_r      <= mask_nxt;
      status_r    <= status_nxt;
      both_r      <= both_nxt;
      prev_pins_r <= prev_pins_nxt;
    end
  end

  // result reflects the state after this transaction
  assign active = status_nxt & mask_nxt;

  always_comb begin
    result.read_data      = (item.req_type == REQ_READ) ? read_word : '0;
    result.irq_low_half   = |active[GPB_HALF_PINS-1:0];
    result.irq_high_half  = |active[GPB_WORD_W-1:GPB_HALF_PINS];
    result.pin_drive      = data_nxt;
    result.pin_out_enable = dir_nxt;
  end

`ifndef SYNTHESIS
  // no status bit ever appears for a missing pin
  a_status_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r & ~PinMask) == '0)
    else $error("status bit set above pin count");

  // a tick leaves the sampled levels behind for the next edge compare
  a_tick_samples: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && item.req_type == REQ_TICK) |=> prev_pins_r == $past(cur_pins))
    else $error("previous pin levels not captured on tick");

  // status bits only rise on a tick
  a_status_sets_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && item.req_type == REQ_TICK) |=> (status_r & ~$past(status_r)) == '0)
    else $error("status bit set outside a tick");
`endif

endmodule

### sv/gpb_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module gpb_out_buf
  import gpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  gpb_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output gpb_out_t out_data
);

  logic     out_valid_r,  out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  gpb_out_t out_data_r;
  gpb_out_t skid_data_r;
  logic     pop;
  logic     load_out;

  assign pop      = out_valid_r && !out_stall;
  assign load_out = !out_valid_r || pop;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (load_out) begin
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a transaction with output empty");

  // never push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("push while skid is occupied");

  // a stalled result stays valid and unchanged
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result dropped or changed");
`endif

endmodule

### sv/gpio_bank_with_pin_interrupts_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_bank_with_pin_interrupts_unit
// 32-pin gpio bank: bus-mapped registers, per-pin edge/level interrupt
// detection and two combined interrupt lines, one result per transaction
// ----------------------------------------------------------------------------
// each result is registered in the output register (or skid, when stalled)
// throughput: one transaction per cycle, sustained while out_stall is low
// in_stall rises only after two results are waiting (output and skid full)
// reset (rst_n low, synchronous) clears every register and previous pin level
// to zero and empties the result buffer
module gpio_bank_with_pin_interrupts_unit
  import gpb_pkg::*;
#(
  parameter int unsigned PIN_COUNT = GPB_PIN_COUNT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gpb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output gpb_out_t out_data
);

  logic     in_accept;
  logic     buf_full;
  gpb_out_t result;

  // stall is a register output, so no path runs from out_stall to in_stall
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  // state update and result formation in the cycle of acceptance
  gpb_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .result (result)
  );

  // result register with a skid entry so input keeps flowing under one stall
  gpb_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
